// ===== hdl/gcd_pkg.sv =====
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared command and status types for the GCD controller and datapath.
// ----------------------------------------------------------------------------
package gcd_pkg;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture operands, clear shift count
    logic step;    // one binary GCD reduction step
    logic finish;  // form the result from the reduced operand
  } gcd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_zero;  // an incoming operand is zero
    logic done;     // working operands are equal and odd
  } gcd_stat_t;

endpackage

// ===== hdl/gcd_datapath.sv =====
// ----------------------------------------------------------------------------
// gcd_datapath
// Working operands, common power-of-two count and result register.
// ----------------------------------------------------------------------------
module gcd_datapath #(
  parameter int OPERAND_BITS = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gcd_pkg::gcd_cmd_t       cmd,
  output gcd_pkg::gcd_stat_t      stat,
  input  logic [OPERAND_BITS-1:0] operand_a,
  input  logic [OPERAND_BITS-1:0] operand_b,
  output logic [OPERAND_BITS-1:0] divisor_out,
  output logic                    zero_error
);

  localparam int KW = $clog2(OPERAND_BITS);

  logic [OPERAND_BITS-1:0] a_r, a_nxt;
  logic [OPERAND_BITS-1:0] b_r, b_nxt;
  logic [KW-1:0]           k_r, k_nxt;
  logic [OPERAND_BITS-1:0] res_r, res_nxt;
  logic                    err_r, err_nxt;
  logic [OPERAND_BITS-1:0] a_minus_b;
  logic [OPERAND_BITS-1:0] b_minus_a;
  logic                    in_zero;

  assign in_zero   = (operand_a == '0) || (operand_b == '0);
  assign a_minus_b = a_r - b_r;
  assign b_minus_a = b_r - a_r;

  assign stat.in_zero = in_zero;
  assign stat.done    = (a_r == b_r) && a_r[0];

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    k_nxt   = k_r;
    res_nxt = res_r;
    err_nxt = err_r;
    if (cmd.load) begin
      a_nxt   = operand_a;
      b_nxt   = operand_b;
      k_nxt   = '0;
      err_nxt = in_zero;
      res_nxt = '0;
    end else if (cmd.finish) begin
      res_nxt = a_r << k_r;
    end else if (cmd.step) begin
      if (!a_r[0] && !b_r[0]) begin
        // common factor of two
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + KW'(1);
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r > b_r) begin
        // odd minus odd is even, so halve right away
        a_nxt = a_minus_b >> 1;
      end else begin
        b_nxt = b_minus_a >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    res_r <= res_nxt;
    if (!rst_n) begin
      err_r <= 1'b0;
    end else begin
      err_r <= err_nxt;
    end
  end

  assign divisor_out = res_r;
  assign zero_error  = err_r;

endmodule

// ===== hdl/gcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcd_ctrl
// Sequencer: load, iterate until the operands meet, hold the result.
// ----------------------------------------------------------------------------
module gcd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output gcd_pkg::gcd_cmd_t  cmd,
  input  gcd_pkg::gcd_stat_t stat
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WORK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign in_ready  = (state_r == ST_IDLE) || ((state_r == ST_DONE) && out_ready);
  assign out_valid = (state_r == ST_DONE);
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = stat.in_zero ? ST_DONE : ST_WORK;
        end
      end
      ST_WORK: begin
        if (stat.done) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = stat.in_zero ? ST_DONE : ST_WORK;
        end else if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/greatest_common_divisor.sv =====
// ----------------------------------------------------------------------------
// greatest_common_divisor
// Binary GCD of two unsigned operands, one result per transaction.
// ----------------------------------------------------------------------------
//  channel | ports                                   | dir | transaction
//  --------+-----------------------------------------+-----+----------------------
//  in      | in_valid in_ready in_operand_a/_b       | in  | two operands
//  out     | out_valid out_ready out_divisor_out     | out | GCD and zero flag
//          | out_zero_error                          |     |
//
//  Sequence: a load, then one reduction step per cycle until the working
//  operands are equal and odd, then a finish step. Steps are data dependent.
//  A zero operand skips the loop: result 0 with out_zero_error set.
//  Reset (rst_n low, synchronous) returns the controller to idle.
//  One transaction in flight; the next is taken in the cycle the result goes.
// ----------------------------------------------------------------------------
module greatest_common_divisor #(
  parameter int OPERAND_BITS = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OPERAND_BITS-1:0] in_operand_a,
  input  logic [OPERAND_BITS-1:0] in_operand_b,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OPERAND_BITS-1:0] out_divisor_out,
  output logic                    out_zero_error
);

  gcd_pkg::gcd_cmd_t  cmd;
  gcd_pkg::gcd_stat_t stat;

  // Controller: sequencing and handshakes
  gcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath: Stein reduction. Common factors of two are counted and
  // restored by a left shift of the odd part at the end.
  gcd_datapath #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .operand_a   (in_operand_a),
    .operand_b   (in_operand_b),
    .divisor_out (out_divisor_out),
    .zero_error  (out_zero_error)
  );

endmodule

// ===== tb/sv/tb_greatest_common_divisor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greatest_common_divisor
// Self-checking bench for the GCD block: a queue-fed driver pushes operand
// pairs, a monitor predicts each GCD at acceptance and checks results in order.
// ----------------------------------------------------------------------------
module tb_greatest_common_divisor;

  localparam int OPERAND_BITS = 31;
  localparam int IDLE_LIMIT   = 1000;  // cycles with no transaction on either side
  localparam int SETTLE       = 80;    // worst-case reduction plus a receiver stall
  localparam int RANDOM_PAIRS = 1800;

  typedef logic [OPERAND_BITS-1:0] operand_t;

  // One pending input transaction: operands, idle cycles before it, and
  // whether the sender must wait for the block to drain first.
  typedef struct {
    operand_t a;
    operand_t b;
    int       gap;
    bit       drain;
  } operand_pair_t;

  typedef struct {
    operand_t divisor;
    logic     zero_err;
  } gcd_result_t;

  logic     clk;
  logic     rst_n           = 1'b0;
  logic     in_valid        = 1'b0;
  logic     in_ready;
  operand_t in_operand_a    = '0;
  operand_t in_operand_b    = '0;
  logic     out_valid;
  logic     out_ready       = 1'b0;
  operand_t out_divisor_out;
  logic     out_zero_error;

  greatest_common_divisor #(
    .OPERAND_BITS(OPERAND_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operand_a   (in_operand_a),
    .in_operand_b   (in_operand_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_divisor_out(out_divisor_out),
    .out_zero_error (out_zero_error)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  operand_pair_t pending_pairs[$];
  gcd_result_t   gcd_expected[$];

  int  pairs_queued  = 0;
  int  items_taken   = 0;   // input transactions, updated with NBA
  int  results_seen  = 0;   // output transactions, updated with NBA
  int  zero_pairs    = 0;
  int  fail_count    = 0;
  int  idle_cycles   = 0;
  bit  timed_out     = 1'b0;
  bit  stimulus_done = 1'b0;

  // Predicted GCD. Plain Euclid here, independent of how the block reduces;
  // either operand zero gives 0 with the error flag.
  function automatic gcd_result_t predict_gcd(operand_t a, operand_t b);
    gcd_result_t res;
    operand_t    x;
    operand_t    y;
    operand_t    r;
    res.divisor  = '0;
    res.zero_err = 1'b1;
    if (a != '0 && b != '0) begin
      x = a;
      y = b;
      while (y != '0) begin
        r = x % y;
        x = y;
        y = r;
      end
      res.divisor  = x;
      res.zero_err = 1'b0;
    end
    return res;
  endfunction

  // Queue one pair. Sender gaps come in bands: every fourth band of 200 pairs
  // runs back to back, the rest take a random idle gap before each transaction.
  task automatic add_pair(operand_t a, operand_t b, bit drain);
    operand_pair_t p;
    p.a     = a;
    p.b     = b;
    p.drain = drain;
    p.gap   = ((pairs_queued / 200) % 4 == 0) ? 0 : $urandom_range(0, 5);
    pending_pairs.push_back(p);
    pairs_queued++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: one pair at a time from pending_pairs. in_valid gets exactly one
  // NBA per edge so back-to-back transactions never glitch low.
  // --------------------------------------------------------------------------
  operand_pair_t tx_pair;
  bit            tx_loaded  = 1'b0;
  bit            tx_sending = 1'b0;
  int            tx_wait    = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      tx_loaded  = 1'b0;
      tx_sending = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        tx_sending = 1'b0;
      end
      if (!tx_sending) begin
        if (!tx_loaded && pending_pairs.size() != 0) begin
          tx_pair   = pending_pairs.pop_front();
          tx_loaded = 1'b1;
          tx_wait   = tx_pair.gap;
        end
        if (tx_loaded) begin
          // drain pairs hold off until every result is back; in_valid still
          // high means the count of taken items may not include the last one
          if (tx_pair.drain && (in_valid || items_taken != results_seen)) begin
            // hold
          end else if (tx_wait > 0) begin
            tx_wait--;
          end else begin
            in_operand_a <= tx_pair.a;
            in_operand_b <= tx_pair.b;
            tx_sending   = 1'b1;
            tx_loaded    = 1'b0;
          end
        end
      end
      in_valid      <= tx_sending;
      stimulus_done <= !tx_sending && !tx_loaded && pending_pairs.size() == 0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks the output transaction against the oldest prediction,
  // then records the prediction for any input transaction on this edge.
  // out_ready drops for a random hold after each result, except in calm bands.
  // --------------------------------------------------------------------------
  gcd_result_t got;
  gcd_result_t want;
  int          rx_hold = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold   = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.divisor  = out_divisor_out;
        got.zero_err = out_zero_error;
        if (gcd_expected.size() == 0) begin
          $display("%0t: result with nothing outstanding: divisor %0d zero_error %0b",
                   $time, got.divisor, got.zero_err);
          fail_count++;
        end else begin
          want = gcd_expected.pop_front();
          if (got.divisor !== want.divisor) begin
            $display("%0t: divisor_out mismatch: expected %0d actual %0d",
                     $time, want.divisor, got.divisor);
            fail_count++;
          end
          if (got.zero_err !== want.zero_err) begin
            $display("%0t: zero_error mismatch: expected %0b actual %0b",
                     $time, want.zero_err, got.zero_err);
            fail_count++;
          end
        end
        results_seen <= results_seen + 1;
        rx_hold = ((results_seen / 150) % 3 == 0) ? 0 : $urandom_range(0, 5);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_ready <= (rx_hold == 0);

      if (in_valid && in_ready) begin
        gcd_expected.push_back(predict_gcd(in_operand_a, in_operand_b));
        if (in_operand_a == '0 || in_operand_b == '0)
          zero_pairs++;
        items_taken <= items_taken + 1;
      end
    end
  end

  // Watchdog: a stretch with no transaction on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT)
        timed_out <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    operand_t    max_op;
    operand_t    a;
    operand_t    b;
    logic [63:0] g;
    logic [63:0] x;
    logic [63:0] y;
    int          gw;
    int          n;

    max_op = '1;

    // directed: zero operands, ones, equal operands, powers of two, worst-case
    // Euclid chain, alternating bit patterns
    add_pair('0, '0, 1'b0);
    add_pair('0, 31'd5, 1'b0);
    add_pair(31'd7, '0, 1'b0);
    add_pair(max_op, '0, 1'b0);
    add_pair('0, max_op, 1'b0);
    add_pair(31'd1, 31'd1, 1'b0);
    add_pair(31'd1, max_op, 1'b0);
    add_pair(max_op, 31'd1, 1'b0);
    add_pair(max_op, max_op, 1'b0);
    add_pair(31'd12345, 31'd12345, 1'b1);   // also the first full drain
    add_pair(31'h4000_0000, 31'h2000_0000, 1'b0);
    add_pair(31'd2, 31'h4000_0000, 1'b0);
    add_pair(max_op, max_op - 1'b1, 1'b0);
    add_pair(31'h4000_0000, 31'd3 << 20, 1'b0);
    add_pair(31'd1836311903, 31'd1134903170, 1'b0);
    add_pair(31'd1134903170, 31'd1836311903, 1'b0);
    add_pair(31'd6, 31'd4, 1'b0);
    add_pair(31'd48, 31'd18, 1'b0);
    add_pair(31'h2AAA_AAAA, 31'h5555_5555, 1'b0);
    add_pair(31'h5555_5555, 31'h2AAA_AAAA, 1'b0);
    add_pair(31'h7FFF_FFFE, 31'h7FFF_FFFC, 1'b0);

    for (n = 0; n < RANDOM_PAIRS; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // unrelated full-width operands
          a = operand_t'($urandom);
          b = operand_t'($urandom);
        end
        3, 4, 5: begin
          // shared factor g, cofactors sized so the product stays in range
          gw = $urandom_range(1, 24);
          g  = 64'($urandom) & ((64'd1 << gw) - 1);
          if (g == 0)
            g = 1;
          x  = 64'($urandom) & ((64'd1 << (OPERAND_BITS - gw)) - 1);
          y  = 64'($urandom) & ((64'd1 << (OPERAND_BITS - gw)) - 1);
          a  = operand_t'(g * x);
          b  = operand_t'(g * y);
        end
        6: begin
          // many trailing zeros on both sides
          a = operand_t'(($urandom & 32'hFFFF) << $urandom_range(0, 15));
          b = operand_t'(($urandom & 32'hFFFF) << $urandom_range(0, 15));
        end
        7: begin
          // mixed magnitudes
          a = operand_t'($urandom) >> $urandom_range(0, 30);
          b = operand_t'($urandom) >> $urandom_range(0, 30);
        end
        8: begin
          // small values, zero included
          a = operand_t'($urandom_range(0, 64));
          b = operand_t'($urandom_range(0, 64));
        end
        default: begin
          // equal operands, an operand of one, or a zero
          a = operand_t'($urandom);
          case ($urandom_range(0, 3))
            0: b = a;
            1: b = 31'd1;
            2: b = '0;
            default: begin
              b = a;
              a = 31'd1;
            end
          endcase
        end
      endcase
      add_pair(a, b, (n % 450) == 449);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (!timed_out && !(stimulus_done && items_taken == results_seen))
      @(posedge clk);
    for (n = 0; n < SETTLE && !timed_out; n++)
      @(posedge clk);

    if (gcd_expected.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, gcd_expected.size());
      fail_count++;
    end

    if (timed_out) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_greatest_common_divisor NOT OK");
    end else begin
      $display("Checked %0d GCD results of %0d operand pairs, %0d with a zero operand,",
               results_seen, items_taken, zero_pairs);
      $display("under random sender gaps and receiver stalls, with full drains between.");
      if (fail_count == 0)
        $display("tb_greatest_common_divisor OK");
      else
        $display("tb_greatest_common_divisor NOT OK");
    end
    $finish;
  end

endmodule

// ===== greatest_common_divisor.f =====
hdl/gcd_pkg.sv
hdl/gcd_datapath.sv
hdl/gcd_ctrl.sv
hdl/greatest_common_divisor.sv
tb/sv/tb_greatest_common_divisor.sv
